/* hw/rtl/lcb_pkg.sv */
package lcb_pkg;

  // Fraction bits of the balance outputs
  localparam int unsigned CenterFracBitsDef = 16;

  // Division lanes
  localparam int unsigned LANES     = 5;
  localparam int unsigned LANE_X    = 0;
  localparam int unsigned LANE_Y    = 1;
  localparam int unsigned LANE_PCS  = 2;
  localparam int unsigned LANE_FULL = 3;
  localparam int unsigned LANE_FILL = 4;

  // Divisor and partial remainder width
  localparam int unsigned DW = 33;

  // Register indexes
  localparam logic [1:0] REG_PIECES_MODE = 2'd0;
  localparam logic [1:0] REG_UNIT_WEIGHT = 2'd1;
  localparam logic [1:0] REG_FULL_WEIGHT = 2'd2;

  localparam logic [30:0] SMALL_WEIGHT    = 31'd10;
  localparam logic [31:0] DEFAULT_DIVISOR = 32'd1000;
  localparam logic [27:0] COUNT_MAX       = 28'hFFFFFFF;
  localparam logic [13:0] FILL_MAX        = 14'd10000;

  // Sideband that travels with each item along the divider row
  typedef struct packed {
    logic flip_x;
    logic flip_y;
    logic imu;
    logic cnt_on;
    logic full_ok;
  } side_t;

endpackage

/* hw/rtl/lcb_prep.sv */
module lcb_prep #(
  parameter int unsigned CenterFracBits = lcb_pkg::CenterFracBitsDef,
  parameter int unsigned NW = 56
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [29:0]                            corner_weight_0_i,
  input  logic [29:0]                            corner_weight_1_i,
  input  logic [29:0]                            corner_weight_2_i,
  input  logic [29:0]                            corner_weight_3_i,
  input  logic [31:0]                            total_weight_i,
  input  logic [31:0]                            raw_weight_i,
  input  logic                                   imu_ready_i,
  input  logic                                   pieces_mode_i,
  input  logic [30:0]                            unit_weight_i,
  input  logic [30:0]                            full_weight_i,
  output logic                                   valid_o,
  output lcb_pkg::side_t                         side_o,
  output logic [lcb_pkg::LANES-1:0][NW-1:0]      num_o,
  output logic [lcb_pkg::LANES-1:0][lcb_pkg::DW-1:0] den_o
);
  import lcb_pkg::*;

  logic signed [31:0] e0, e1, e2, e3, dx, dy, sel, div;
  logic [31:0] mag_x, mag_y, dmag;
  logic [30:0] tpos;
  logic [44:0] fill_num;
  side_t side_d;
  logic [LANES-1:0][NW-1:0] num_d;
  logic [LANES-1:0][DW-1:0] den_d;
  logic valid_q;
  side_t side_q;
  logic [LANES-1:0][NW-1:0] num_q;
  logic [LANES-1:0][DW-1:0] den_q;

  // Form the differences, divisor and numerators
  always_comb begin
    e0 = {{2{corner_weight_0_i[29]}}, corner_weight_0_i};
    e1 = {{2{corner_weight_1_i[29]}}, corner_weight_1_i};
    e2 = {{2{corner_weight_2_i[29]}}, corner_weight_2_i};
    e3 = {{2{corner_weight_3_i[29]}}, corner_weight_3_i};
    dx = (e1 + e3) - (e0 + e2);
    dy = (e0 + e1) - (e2 + e3);
    mag_x = dx[31] ? 32'(-dx) : 32'(dx);
    mag_y = dy[31] ? 32'(-dy) : 32'(dy);
    sel = (raw_weight_i != 32'd0) ? $signed(raw_weight_i) : $signed(total_weight_i);
    div = (sel == 32'sd0) ? $signed(DEFAULT_DIVISOR) : sel;
    dmag = div[31] ? 32'(-div) : 32'(div);
    tpos = (!total_weight_i[31] && total_weight_i != 32'd0) ? total_weight_i[30:0] : 31'd0;
    fill_num = 45'(tpos) * 45'(10000);

    num_d[LANE_X]    = NW'({mag_x, {CenterFracBits{1'b0}}});
    num_d[LANE_Y]    = NW'({mag_y, {CenterFracBits{1'b0}}});
    num_d[LANE_PCS]  = NW'(33'({tpos, 1'b0}) + 33'(unit_weight_i));
    num_d[LANE_FULL] = NW'(33'({full_weight_i, 1'b0}) + 33'(unit_weight_i));
    num_d[LANE_FILL] = NW'(fill_num);
    den_d[LANE_X]    = DW'(dmag);
    den_d[LANE_Y]    = DW'(dmag);
    den_d[LANE_PCS]  = DW'({unit_weight_i, 1'b0});
    den_d[LANE_FULL] = DW'({unit_weight_i, 1'b0});
    den_d[LANE_FILL] = DW'(full_weight_i);

    side_d.flip_x  = dx[31] ^ div[31];
    side_d.flip_y  = dy[31] ^ div[31];
    side_d.imu     = imu_ready_i;
    side_d.cnt_on  = pieces_mode_i && (unit_weight_i > SMALL_WEIGHT);
    side_d.full_ok = full_weight_i > SMALL_WEIGHT;
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Register the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

/* hw/rtl/lcb_div_cell.sv */
module lcb_div_cell #(
  parameter int unsigned NW = 56
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  lcb_pkg::side_t                             side_i,
  input  logic [lcb_pkg::LANES-1:0][lcb_pkg::DW-1:0] den_i,
  input  logic [lcb_pkg::LANES-1:0][lcb_pkg::DW-1:0] rem_i,
  input  logic [lcb_pkg::LANES-1:0][NW-1:0]          quo_i,
  output logic                                       valid_o,
  output lcb_pkg::side_t                             side_o,
  output logic [lcb_pkg::LANES-1:0][lcb_pkg::DW-1:0] den_o,
  output logic [lcb_pkg::LANES-1:0][lcb_pkg::DW-1:0] rem_o,
  output logic [lcb_pkg::LANES-1:0][NW-1:0]          quo_o
);
  import lcb_pkg::*;

  logic [DW:0] trial [LANES];
  logic [LANES-1:0][DW-1:0] rem_d;
  logic [LANES-1:0][NW-1:0] quo_d;
  logic valid_q;
  side_t side_q;
  logic [LANES-1:0][DW-1:0] den_q, rem_q;
  logic [LANES-1:0][NW-1:0] quo_q;

  // One restoring step per lane: bring in the next numerator bit, subtract if it fits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = {rem_i[l], quo_i[l][NW-1]};
      if (trial[l] >= {1'b0, den_i[l]}) begin
        rem_d[l] = DW'(trial[l] - {1'b0, den_i[l]});
        quo_d[l] = {quo_i[l][NW-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[l][DW-1:0];
        quo_d[l] = {quo_i[l][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance the item to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      den_q  <= den_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

/* hw/rtl/load_cell_balance_and_count.sv */
// Four-corner load-cell balance and piece counter.
// Input items arrive on the s_axis stream (corner, total and raw weights in
// tdata, the inertial-sensor ready flag in tuser); one result item per input
// leaves on the m_axis stream (balance, tilt, counts and fill in tdata, the
// tilt-from-balance flag in tuser). pieces_mode, unit_weight and full_weight
// are written over the APB port at byte addresses 0, 4 and 8; the user must
// write them only while idle, which the block does not enforce. All divisions
// run in a row of identical restoring-divider cells, five lanes wide, one
// quotient bit per cell. The row is NW = max(32 + CenterFracBits, 45) cells
// long (48 at the default), between the prep and output registers. A new item
// is accepted in each cycle that the row is not stalled: one item per cycle.
// When the receiver stalls with a result waiting, the whole row holds and
// s_axis_tready drops in the same cycle; it rises again once the result is
// taken. Reset empties the row and the output register and clears the three
// registers to zero.
module load_cell_balance_and_count #(
  parameter int unsigned CenterFracBits = lcb_pkg::CenterFracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // corner_weight_0..3 (4 x 30), total_weight (32), raw_weight (32)
  input  logic [183:0] s_axis_tdata,
  // imu_ready
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // center_x, center_y, tilt_x, tilt_y (32 each), piece_count, full_count,
  // removed_count (28 each), fill_hundredths (14), 6 zero bits
  output logic [231:0] m_axis_tdata,
  // tilt_from_balance
  output logic         m_axis_tuser
);
  import lcb_pkg::*;

  localparam int unsigned NW = (32 + CenterFracBits > 45) ? 32 + CenterFracBits : 45;

  logic        pieces_mode_q;
  logic [30:0] unit_weight_q, full_weight_q;
  logic        en;
  logic        out_valid_q;
  logic [225:0] out_data_q, out_data_d;
  logic        out_flag_q;

  logic                      stg_valid [NW+1];
  side_t                     stg_side  [NW+1];
  logic [LANES-1:0][DW-1:0]  stg_den   [NW+1];
  logic [LANES-1:0][DW-1:0]  stg_rem   [NW+1];
  logic [LANES-1:0][NW-1:0]  stg_quo   [NW+1];

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pieces_mode_q <= 1'b0;
      unit_weight_q <= 31'd0;
      full_weight_q <= 31'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_PIECES_MODE: pieces_mode_q <= pwdata[0];
        REG_UNIT_WEIGHT: unit_weight_q <= pwdata[30:0];
        REG_FULL_WEIGHT: full_weight_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PIECES_MODE: prdata = {31'd0, pieces_mode_q};
      REG_UNIT_WEIGHT: prdata = {1'b0, unit_weight_q};
      REG_FULL_WEIGHT: prdata = {1'b0, full_weight_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Advance the whole row unless a result waits on a stalled receiver
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  lcb_prep #(
    .CenterFracBits(CenterFracBits),
    .NW            (NW)
  ) u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (s_axis_tvalid),
    .corner_weight_0_i(s_axis_tdata[29:0]),
    .corner_weight_1_i(s_axis_tdata[59:30]),
    .corner_weight_2_i(s_axis_tdata[89:60]),
    .corner_weight_3_i(s_axis_tdata[119:90]),
    .total_weight_i   (s_axis_tdata[151:120]),
    .raw_weight_i     (s_axis_tdata[183:152]),
    .imu_ready_i      (s_axis_tuser),
    .pieces_mode_i    (pieces_mode_q),
    .unit_weight_i    (unit_weight_q),
    .full_weight_i    (full_weight_q),
    .valid_o          (stg_valid[0]),
    .side_o           (stg_side[0]),
    .num_o            (stg_quo[0]),
    .den_o            (stg_den[0])
  );

  assign stg_rem[0] = '0;

  // Row of divider cells
  for (genvar k = 0; k < NW; k++) begin : g_cell
    lcb_div_cell #(.NW(NW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(stg_valid[k]),
      .side_i (stg_side[k]),
      .den_i  (stg_den[k]),
      .rem_i  (stg_rem[k]),
      .quo_i  (stg_quo[k]),
      .valid_o(stg_valid[k+1]),
      .side_o (stg_side[k+1]),
      .den_o  (stg_den[k+1]),
      .rem_o  (stg_rem[k+1]),
      .quo_o  (stg_quo[k+1])
    );
  end

  function automatic logic [31:0] sat32(input logic neg, input logic big,
                                        input logic [31:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = big ? 32'h80000000 : 32'(-mag);
    end else begin
      r = big ? 32'h7FFFFFFF : mag;
    end
    return r;
  endfunction

  function automatic logic [27:0] sat28(input logic [NW-1:0] q);
    return (q > NW'(COUNT_MAX)) ? COUNT_MAX : q[27:0];
  endfunction

  // Saturate the quotients and form the result
  logic [NW-1:0] qx, qy;
  logic nx, ny, bx, by, tbx, tby;
  logic [31:0] tx10, ty10, cx, cy, tx, ty;
  logic [27:0] pcs, full, removed;
  logic [13:0] fill;
  side_t se;

  always_comb begin
    se   = stg_side[NW];
    qx   = stg_quo[NW][LANE_X];
    qy   = stg_quo[NW][LANE_Y];
    nx   = se.flip_x && (qx != '0);
    ny   = se.flip_y && (qy != '0);
    bx   = |qx[NW-1:31];
    by   = |qy[NW-1:31];
    tbx  = qx >= NW'(214748365);
    tby  = qy >= NW'(214748365);
    tx10 = {qx[28:0], 3'b000} + {qx[30:0], 1'b0};
    ty10 = {qy[28:0], 3'b000} + {qy[30:0], 1'b0};
    cx   = sat32(nx, bx, qx[31:0]);
    cy   = sat32(ny, by, qy[31:0]);
    tx   = se.imu ? 32'd0 : sat32(nx, tbx, tx10);
    ty   = se.imu ? 32'd0 : sat32(ny, tby, ty10);

    pcs     = 28'd0;
    full    = 28'd0;
    removed = 28'd0;
    if (se.cnt_on) begin
      pcs = sat28(stg_quo[NW][LANE_PCS]);
      if (se.full_ok) begin
        full    = sat28(stg_quo[NW][LANE_FULL]);
        removed = (full > pcs) ? full - pcs : 28'd0;
      end else begin
        full = pcs;
      end
    end

    fill = 14'd0;
    if (se.full_ok) begin
      fill = (stg_quo[NW][LANE_FILL] > NW'(FILL_MAX)) ? FILL_MAX
                                                      : stg_quo[NW][LANE_FILL][13:0];
    end

    out_data_d = {fill, removed, full, pcs, ty, tx, cy, cx};
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= stg_valid[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_flag_q <= !se.imu;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};
  assign m_axis_tuser  = out_flag_q;

endmodule

/* hw/rtl/lcb_checker.sv */
module lcb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         pready,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [231:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // Input side stalls exactly while a result waits on the receiver
  a_ready_follows_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
    else $error("input ready does not follow output stall");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Fill never exceeds one hundred percent
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[225:212] <= 14'd10000)
    else $error("fill out of range");

  // Tilt fields are zero when not derived from balance
  a_tilt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[127:64] == 64'd0)
    else $error("tilt given while sensor ready");

  // Removed count never exceeds full count
  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[211:184] <= m_axis_tdata[183:156] && pready)
    else $error("removed count above full count");

endmodule

bind load_cell_balance_and_count lcb_checker u_lcb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
